FILE: hw/rtl/sts_pkg.sv
// Shared constants and types for the sorted table search core.
// No dependencies; used by every module of the block except sts_ram.
package sts_pkg;

    localparam int unsigned TABLE_DEPTH = 1024;
    localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int unsigned PTR_W       = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned VAL_W       = 32;
    localparam int unsigned IDX_W       = 10;
    localparam int unsigned SIZE_W      = 11;
    localparam int unsigned PADDR_W     = 3;
    localparam int unsigned PDATA_W     = 32;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic REG_TABLE_SIZE = 1'b0;

    typedef struct packed {
        logic load;
        logic probe;
        logic set_hit;
        logic set_miss;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic hit;
        logic cont;
    } dp_status_t;

endpackage

FILE: hw/rtl/sts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sts_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/sts_datapath.sv
// Search datapath: bounds, probe index, key, table RAM and result index.
// Depends on sts_pkg and sts_ram.
module sts_datapath (
    input  logic                          clk,
    input  sts_pkg::dp_cmd_t              dp_cmd,
    output sts_pkg::dp_status_t           dp_status,
    input  logic [sts_pkg::SIZE_W-1:0]    table_size,
    input  logic signed [sts_pkg::VAL_W-1:0] key,
    input  logic                          wr_en,
    input  logic [sts_pkg::ADDR_W-1:0]    wr_addr,
    input  logic [sts_pkg::VAL_W-1:0]     wr_data,
    output logic [sts_pkg::IDX_W-1:0]     found_index
);

    logic [sts_pkg::PTR_W-1:0]        lo_reg, lo_next;
    logic [sts_pkg::PTR_W-1:0]        hi_reg, hi_next;
    logic [sts_pkg::ADDR_W-1:0]       mid_reg, mid_next;
    logic signed [sts_pkg::VAL_W-1:0] key_reg;
    logic [sts_pkg::IDX_W-1:0]        found_index_reg;

    logic [sts_pkg::PTR_W-1:0]        hi0;
    logic [sts_pkg::PTR_W-1:0]        lo_n, hi_n;
    logic [sts_pkg::PTR_W:0]          sum_n;
    logic [sts_pkg::VAL_W-1:0]        rdata;
    logic signed [sts_pkg::VAL_W-1:0] entry;
    logic                             rd_en;

    // clamp the search range to the table
    always_comb
    begin
        if (32'(table_size) > sts_pkg::TABLE_DEPTH)
        begin
            hi0 = sts_pkg::PTR_W'(sts_pkg::TABLE_DEPTH);
        end
        else
        begin
            hi0 = sts_pkg::PTR_W'(table_size);
        end
    end

    assign entry = $signed(rdata);

    always_comb
    begin
        if (entry < key_reg)
        begin
            lo_n = sts_pkg::PTR_W'(mid_reg) + sts_pkg::PTR_W'(1);
            hi_n = hi_reg;
        end
        else
        begin
            lo_n = lo_reg;
            hi_n = sts_pkg::PTR_W'(mid_reg);
        end
        sum_n = {1'b0, lo_n} + {1'b0, hi_n};
    end

    assign dp_status.empty = (hi0 == '0);
    assign dp_status.hit   = (entry == key_reg);
    assign dp_status.cont  = (lo_n < hi_n);

    always_comb
    begin
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        mid_next = mid_reg;
        if (dp_cmd.load)
        begin
            lo_next  = '0;
            hi_next  = hi0;
            mid_next = sts_pkg::ADDR_W'(hi0 >> 1);
        end
        else if (dp_cmd.probe)
        begin
            lo_next  = lo_n;
            hi_next  = hi_n;
            mid_next = sts_pkg::ADDR_W'(sum_n[sts_pkg::PTR_W:1]);
        end
    end

    assign rd_en = dp_cmd.load || dp_cmd.probe;

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        if (dp_cmd.load)
        begin
            key_reg <= key;
        end
        if (dp_cmd.set_hit)
        begin
            found_index_reg <= sts_pkg::IDX_W'(mid_reg);
        end
        else if (dp_cmd.set_miss)
        begin
            found_index_reg <= '0;
        end
    end

    sts_ram #(
        .WIDTH (sts_pkg::VAL_W),
        .DEPTH (sts_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (mid_next),
        .rdata (rdata)
    );

    assign found_index = found_index_reg;

endmodule

FILE: hw/rtl/sts_ctrl.sv
// Search controller: accepts search items, steps probes, raises the result strobe.
// Depends on sts_pkg.
module sts_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                search_go,
    output logic                busy,
    output sts_pkg::dp_cmd_t    dp_cmd,
    input  sts_pkg::dp_status_t dp_status,
    output logic                done,
    output logic                found
);

    typedef enum logic {
        ST_IDLE,
        ST_PROBE
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;
    logic   found_reg, found_next;

    always_comb
    begin
        state_next      = state_reg;
        dp_cmd.load     = 1'b0;
        dp_cmd.probe    = 1'b0;
        dp_cmd.set_hit  = 1'b0;
        dp_cmd.set_miss = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (search_go)
                begin
                    dp_cmd.load = 1'b1;
                    if (dp_status.empty)
                    begin
                        dp_cmd.set_miss = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                dp_cmd.probe = 1'b1;
                if (dp_status.hit)
                begin
                    dp_cmd.set_hit = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (!dp_status.cont)
                begin
                    dp_cmd.set_miss = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        done_next  = dp_cmd.set_hit || dp_cmd.set_miss;
        found_next = dp_cmd.set_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            found_reg <= found_next;
        end
    end

    assign busy  = (state_reg == ST_PROBE);
    assign done  = done_reg;
    assign found = found_reg;

endmodule

FILE: hw/rtl/sorted_table_binary_search_core.sv
// Top level of the sorted table binary search core: APB register, item decode.
// Depends on sts_pkg, sts_ctrl, sts_datapath (and through it sts_ram).
//
// Channel   Ports                                        Handshake
// input     cmd, entry_index, entry_value                start high, busy low
// result    found, found_index                           done high for one cycle
// config    psel penable pwrite paddr pwdata prdata      APB, pready tied high
//
// A write item leaves busy low, and no result follows.
// A search item gives its result after its probes, P the probe count (at most
// 11 for 1024 entries): one probe per cycle, paced by the RAM's registered read.
// An empty range answers in the cycle after the item.
// Reset clears table_size and the controller; table contents are not cleared.
// The result strobe cannot be stalled.
module sorted_table_binary_search_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cmd,
    input  logic [sts_pkg::IDX_W-1:0]         entry_index,
    input  logic signed [sts_pkg::VAL_W-1:0]  entry_value,
    output logic                              done,
    output logic                              found,
    output logic [sts_pkg::IDX_W-1:0]         found_index,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sts_pkg::PADDR_W-1:0]       paddr,
    input  logic [sts_pkg::PDATA_W-1:0]       pwdata,
    output logic [sts_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    logic [sts_pkg::SIZE_W-1:0] table_size_reg;
    logic                       accept;
    logic                       search_go;
    logic                       wr_en;
    logic                       apb_wr;
    sts_pkg::dp_cmd_t           dp_cmd;
    sts_pkg::dp_status_t        dp_status;

    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= '0;
        end
        else if (apb_wr && (paddr[2] == sts_pkg::REG_TABLE_SIZE))
        begin
            table_size_reg <= pwdata[sts_pkg::SIZE_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            sts_pkg::REG_TABLE_SIZE: prdata = sts_pkg::PDATA_W'(table_size_reg);
            default:                 prdata = '0;
        endcase
    end

    assign accept    = start && !busy;
    assign search_go = accept && (cmd == sts_pkg::CMD_SEARCH);
    assign wr_en     = accept && (cmd == sts_pkg::CMD_WRITE)
                       && (32'(entry_index) < sts_pkg::TABLE_DEPTH);

    sts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .search_go (search_go),
        .busy      (busy),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .done      (done),
        .found     (found)
    );

    sts_datapath u_datapath (
        .clk         (clk),
        .dp_cmd      (dp_cmd),
        .dp_status   (dp_status),
        .table_size  (table_size_reg),
        .key         (entry_value),
        .wr_en       (wr_en),
        .wr_addr     (sts_pkg::ADDR_W'(entry_index)),
        .wr_data     (entry_value),
        .found_index (found_index)
    );

endmodule
